[design/sfc_pkg.sv]
// ----------------------------------------------------------------------------
// sfc_pkg: shared types and constants of the sphere/frustum classifier
// Register indexes, result codes and the beat carried along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package sfc_pkg;

	localparam int PLANE_COUNT = 6;

	// configuration register indexes
	localparam logic [2:0] REG_BOUND  = 3'd6;
	localparam logic [2:0] REG_ENABLE = 3'd7;

	// view_state codes
	localparam logic [1:0] VIEW_OUTSIDE = 2'd0;
	localparam logic [1:0] VIEW_PARTIAL = 2'd1;
	localparam logic [1:0] VIEW_INSIDE  = 2'd2;

	// one sphere in flight, with the verdict gathered so far
	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		logic [14:0] r;
		logic        outside;
		logic        partial;
	} item_t;

endpackage

`default_nettype wire

[design/sphere_frustum_classify_unit.sv]
// ----------------------------------------------------------------------------
// sphere_frustum_classify_unit: six-plane sphere/frustum classifier
// Classifies each bounding sphere as outside, partial or inside the frustum.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                | beat contents
//  ---------+-----------+--------------------------+-----------------------------
//  sphere   | in        | sphere_valid/sphere_stall| center_x/y/z, radius
//  result   | out       | result_valid/result_stall| view_state
//  cfg      | in        | cfg_valid/cfg_ready      | cfg_index, cfg_data
//
//  One sphere beat per cycle while the result side keeps up; a beat passes
//  the pretest, each plane cell in turn and the output register.
//  Each cell holds one plane's products and distance compare; the chain of
//  cells sets the latency, a single 16x16 multiply per term sets the clock.
//  Reset clears the valid flags and the configuration registers, which
//  leaves every plane all-zero; the data registers are not reset.
//  A stalled result holds; the chain keeps filling behind it, collapsing
//  bubbles, and only stalls the sphere side once every stage holds a beat.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_frustum_classify_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// sphere channel
	input  wire logic          sphere_valid,
	output logic               sphere_stall,
	input  wire logic [15:0]   center_x,
	input  wire logic [15:0]   center_y,
	input  wire logic [15:0]   center_z,
	input  wire logic [14:0]   radius,
	// result channel
	output logic               result_valid,
	input  wire logic          result_stall,
	output logic [1:0]         view_state,
	// configuration channel
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [63:0]   cfg_data
);

	// configuration registers
	logic [63:0] plane_q [sfc_pkg::PLANE_COUNT];
	logic [63:0] bound_q;
	logic        enable_q;

	// chain plumbing: slot 0 is the pretest output, slot k+1 follows cell k
	sfc_pkg::item_t chain_item  [sfc_pkg::PLANE_COUNT+1];
	logic           chain_valid [sfc_pkg::PLANE_COUNT+1];
	logic           chain_ready [sfc_pkg::PLANE_COUNT+1];

	sfc_pkg::item_t in_item;
	logic           pre_ready;
	logic           out_ready;
	logic           result_valid_q;
	logic [1:0]     view_state_q;
	sfc_pkg::item_t last_item;

	// config writes are always taken; the user must write only while the block is idle, it does not enforce this
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sfc_pkg::PLANE_COUNT; i++) begin
				plane_q[i] <= '0;
			end
			bound_q  <= '0;
			enable_q <= 1'b0;
		end else if (cfg_valid) begin
			for (int i = 0; i < sfc_pkg::PLANE_COUNT; i++) begin
				if (cfg_index == 3'(i)) plane_q[i] <= cfg_data;
			end
			if (cfg_index == sfc_pkg::REG_BOUND)  bound_q  <= cfg_data;
			if (cfg_index == sfc_pkg::REG_ENABLE) enable_q <= cfg_data[0];
		end
	end

	// pack the incoming sphere beat with a clean verdict
	always_comb begin
		in_item         = '0;
		in_item.x       = center_x;
		in_item.y       = center_y;
		in_item.z       = center_z;
		in_item.r       = radius;
		in_item.outside = 1'b0;
		in_item.partial = 1'b0;
	end

	assign sphere_stall = !pre_ready;

	sfc_pretest u_pretest (
		.clk      (clk),
		.arst_n   (arst_n),
		.bound    (bound_q),
		.enable   (enable_q),
		.up_valid (sphere_valid),
		.up_ready (pre_ready),
		.up_item  (in_item),
		.dn_valid (chain_valid[0]),
		.dn_ready (chain_ready[0]),
		.dn_item  (chain_item[0])
	);

	// one cell per plane, each handing its beat to the next
	for (genvar k = 0; k < sfc_pkg::PLANE_COUNT; k++) begin : g_cell
		sfc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.plane    (plane_q[k]),
			.up_valid (chain_valid[k]),
			.up_ready (chain_ready[k]),
			.up_item  (chain_item[k]),
			.dn_valid (chain_valid[k+1]),
			.dn_ready (chain_ready[k+1]),
			.dn_item  (chain_item[k+1])
		);
	end

	// output register: advance when empty or when the beat is taken
	assign out_ready                          = !result_valid_q || !result_stall;
	assign chain_ready[sfc_pkg::PLANE_COUNT]  = out_ready;
	assign last_item                          = chain_item[sfc_pkg::PLANE_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_ready) begin
			result_valid_q <= chain_valid[sfc_pkg::PLANE_COUNT];
		end
	end

	// outside dominates partial, partial dominates inside
	always_ff @(posedge clk) begin
		if (out_ready && chain_valid[sfc_pkg::PLANE_COUNT]) begin
			if (last_item.outside) begin
				view_state_q <= sfc_pkg::VIEW_OUTSIDE;
			end else if (last_item.partial) begin
				view_state_q <= sfc_pkg::VIEW_PARTIAL;
			end else begin
				view_state_q <= sfc_pkg::VIEW_INSIDE;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign view_state   = view_state_q;

endmodule

`default_nettype wire

[design/sfc_pretest.sv]
// ----------------------------------------------------------------------------
// sfc_pretest: bounding sphere pretest
// Squares the center offsets and the radius sum, then compares the sums.
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_pretest (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [63:0]   bound,
	input  wire logic          enable,
	input  wire logic          up_valid,
	output logic               up_ready,
	input  wire sfc_pkg::item_t up_item,
	output logic               dn_valid,
	input  wire logic          dn_ready,
	output sfc_pkg::item_t     dn_item
);

	logic                v_s1, v_s2;
	logic                rdy_s1, rdy_s2;
	sfc_pkg::item_t      item_s1, item_s2;
	sfc_pkg::item_t      item_nx;
	logic        [31:0]  sqx_s1, sqy_s1, sqz_s1;
	logic        [33:0]  rs2_s1;
	logic signed [16:0]  dx, dy, dz;
	logic signed [33:0]  sqx, sqy, sqz;
	logic        [16:0]  rs;
	logic        [33:0]  rs2;
	logic        [33:0]  dsum;

	assign rdy_s2   = !v_s2 || dn_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	always_comb begin
		dx  = $signed({up_item.x[15], up_item.x}) - $signed({bound[15], bound[15:0]});
		dy  = $signed({up_item.y[15], up_item.y}) - $signed({bound[31], bound[31:16]});
		dz  = $signed({up_item.z[15], up_item.z}) - $signed({bound[47], bound[47:32]});
		sqx = dx * dx;
		sqy = dy * dy;
		sqz = dz * dz;
		rs  = {2'b00, up_item.r} + {1'b0, bound[63:48]};
		rs2 = rs * rs;
	end

	// |offset| stays below 2^16, so each square fits 32 bits
	assign dsum = {2'b00, sqx_s1} + {2'b00, sqy_s1} + {2'b00, sqz_s1};

	// start a clean verdict: outside only when the pretest rejects
	always_comb begin
		item_nx         = item_s1;
		item_nx.outside = enable && (rs2_s1 < dsum);
		item_nx.partial = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= up_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			item_s1 <= up_item;
			sqx_s1  <= sqx[31:0];
			sqy_s1  <= sqy[31:0];
			sqz_s1  <= sqz[31:0];
			rs2_s1  <= rs2;
		end
		if (rdy_s2 && v_s1) begin
			item_s2 <= item_nx;
		end
	end

	assign dn_valid = v_s2;
	assign dn_item  = item_s2;

endmodule

`default_nettype wire

[design/sfc_cell.sv]
// ----------------------------------------------------------------------------
// sfc_cell: one plane test cell
// Forms the signed plane distance in two steps and merges its verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [63:0]   plane,
	input  wire logic          up_valid,
	output logic               up_ready,
	input  wire sfc_pkg::item_t up_item,
	output logic               dn_valid,
	input  wire logic          dn_ready,
	output sfc_pkg::item_t     dn_item
);

	logic                v_s1, v_s2;
	logic                rdy_s1, rdy_s2;
	sfc_pkg::item_t      item_s1, item_s2;
	sfc_pkg::item_t      item_nx;
	logic signed [31:0]  px, py, pz;
	logic signed [31:0]  px_s1, py_s1, pz_s1;
	logic signed [34:0]  pdist, rq, nrq;

	assign rdy_s2   = !v_s2 || dn_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	assign px = $signed(plane[15:0])  * $signed(up_item.x);
	assign py = $signed(plane[31:16]) * $signed(up_item.y);
	assign pz = $signed(plane[47:32]) * $signed(up_item.z);

	// distance and radius both in units of 2^-14
	assign pdist = 35'(px_s1) + 35'(py_s1) + 35'(pz_s1)
		+ $signed({{5{plane[63]}}, plane[63:48], 14'b0});
	assign rq    = $signed({6'b0, item_s1.r, 14'b0});
	assign nrq   = -rq;

	always_comb begin
		item_nx         = item_s1;
		item_nx.outside = item_s1.outside || (pdist <= nrq);
		item_nx.partial = item_s1.partial || (pdist <= rq);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= up_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			item_s1 <= up_item;
			px_s1   <= px;
			py_s1   <= py;
			pz_s1   <= pz;
		end
		if (rdy_s2 && v_s1) begin
			item_s2 <= item_nx;
		end
	end

	assign dn_valid = v_s2;
	assign dn_item  = item_s2;

endmodule

`default_nettype wire

[design/sfc_checker.sv]
// ----------------------------------------------------------------------------
// sfc_checker: port-level checks for the sphere/frustum classifier
// Watches the channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        sphere_stall,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic [1:0]  view_state,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready
);

	// a held result keeps its beat
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(view_state))
		else $error("result beat dropped or changed under stall");

	// the sphere side only backs up once the result side is backed up
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sphere_stall |-> result_valid && result_stall)
		else $error("sphere stalled while result side is free");

	// the code for value 3 never leaves the block
	a_code_legal: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> view_state != 2'd3)
		else $error("illegal view_state code");

	// config writes never wait
	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

endmodule

bind sphere_frustum_classify_unit sfc_checker u_sfc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sphere_stall (sphere_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.view_state   (view_state),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready)
);

`default_nettype wire

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for sphere_frustum_classify_unit
// Runs a directed table and then random spheres against a series of frustum
// settings, predicts each untyped view_state in the bench, compares each
// result beat in order; random stalls on both channels, long ones on results.
// ----------------------------------------------------------------------------

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     HALF_PERIOD  = 5;
	localparam int     IDLE_LIMIT   = 3000;  // cycles with no beat anywhere
	localparam int     LONG_HOLD    = 300;   // long result-side hold-off
	localparam int     DRAIN_CYCLES = 40;    // extra wait after the last result is back
	localparam int     PHASE_ITEMS  = 240;
	localparam longint Q_ONE        = 16384;

	// plane register indexes, in register order
	localparam logic [2:0] REG_NEAR   = 3'd0;
	localparam logic [2:0] REG_FAR    = 3'd1;
	localparam logic [2:0] REG_LEFT   = 3'd2;
	localparam logic [2:0] REG_RIGHT  = 3'd3;
	localparam logic [2:0] REG_BOTTOM = 3'd4;
	localparam logic [2:0] REG_TOP    = 3'd5;

	typedef enum logic {ROW_CFG, ROW_SPHERE} row_kind_t;
	typedef enum int {FR_BOX, FR_WILD, FR_EXTREME, FR_ZERO} frustum_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [2:0]  idx;
		logic [63:0] data;
		logic [15:0] x, y, z;
		logic [14:0] r;
		bit          typed;   // expected view_state written into the row
		logic [1:0]  vs;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        sphere_valid;
	logic        sphere_stall;
	logic [15:0] center_x, center_y, center_z;
	logic [14:0] radius;
	logic        result_valid;
	logic        result_stall;
	logic [1:0]  view_state;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	// bench copy of the frustum registers
	logic [63:0] plane_q [sfc_pkg::PLANE_COUNT];
	logic [63:0] bound_q;
	logic        pretest_on;

	logic [1:0]  pending_vs [$];
	logic [1:0]  vs_want;
	row_t        dir_rows [$];

	int n_err, n_spheres, n_results, n_settings, idle_cycles;
	int n_class [4];
	bit src_idle_on, sink_idle_on, long_hold_req;

	// center and half extents of the current box frustum
	int fc [3];
	int fh [3];

	sphere_frustum_classify_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sphere_valid (sphere_valid),
		.sphere_stall (sphere_stall),
		.center_x     (center_x),
		.center_y     (center_y),
		.center_z     (center_z),
		.radius       (radius),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.view_state   (view_state),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Classify one sphere against the bench copy of the frustum. Every term is
	// exact in 64 bits: products and sums stay below 2^34.
	function automatic logic [1:0] classify_sphere(logic [15:0] x, logic [15:0] y,
			logic [15:0] z, logic [14:0] r);
		longint sx, sy, sz, rq, dx, dy, dz, rs, pdist;
		bit     near_edge;
		sx = longint'($signed(x));
		sy = longint'($signed(y));
		sz = longint'($signed(z));
		rq = longint'(r) * Q_ONE;
		near_edge = 1'b0;
		if (pretest_on) begin
			dx = sx - longint'($signed(bound_q[15:0]));
			dy = sy - longint'($signed(bound_q[31:16]));
			dz = sz - longint'($signed(bound_q[47:32]));
			rs = longint'(r) + longint'(bound_q[63:48]);
			// equality of the two squares still goes on to the planes
			if (rs * rs < dx * dx + dy * dy + dz * dz)
				return sfc_pkg::VIEW_OUTSIDE;
		end
		for (int i = 0; i < sfc_pkg::PLANE_COUNT; i++) begin
			pdist = longint'($signed(plane_q[i][15:0])) * sx
				+ longint'($signed(plane_q[i][31:16])) * sy
				+ longint'($signed(plane_q[i][47:32])) * sz
				+ longint'($signed(plane_q[i][63:48])) * Q_ONE;
			// any plane fully behind wins over an earlier straddling one
			if (pdist <= -rq)
				return sfc_pkg::VIEW_OUTSIDE;
			if (pdist <= rq)
				near_edge = 1'b1;
		end
		return near_edge ? sfc_pkg::VIEW_PARTIAL : sfc_pkg::VIEW_INSIDE;
	endfunction

	function automatic row_t sph(logic [15:0] x, logic [15:0] y, logic [15:0] z,
			logic [14:0] r, bit typed = 1'b0, logic [1:0] vs = sfc_pkg::VIEW_OUTSIDE);
		row_t row;
		row.kind  = ROW_SPHERE;
		row.idx   = '0;
		row.data  = '0;
		row.x     = x;
		row.y     = y;
		row.z     = z;
		row.r     = r;
		row.typed = typed;
		row.vs    = vs;
		return row;
	endfunction

	function automatic row_t cfg(logic [2:0] idx, logic [63:0] data);
		row_t row;
		row = sph('0, '0, '0, '0);
		row.kind = ROW_CFG;
		row.idx  = idx;
		row.data = data;
		return row;
	endfunction

	// pack a,b,c (Q1.14) and d (world units) into one plane word
	function automatic logic [63:0] plane_word(int a, int b, int c, int d);
		return {d[15:0], c[15:0], b[15:0], a[15:0]};
	endfunction

	function automatic logic [15:0] pick_extreme();
		case ($urandom_range(0, 3))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			default: return 16'h0000;
		endcase
	endfunction

	// Offer one sphere beat and hold it until accepted; record its verdict.
	task automatic send_sphere(logic [15:0] x, logic [15:0] y, logic [15:0] z,
			logic [14:0] r, bit typed = 1'b0, logic [1:0] vs = sfc_pkg::VIEW_OUTSIDE);
		if (src_idle_on && $urandom_range(0, 5) == 0) begin
			sphere_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		sphere_valid <= 1'b1;
		center_x     <= x;
		center_y     <= y;
		center_z     <= z;
		radius       <= r;
		do @(posedge clk); while (sphere_stall);
		pending_vs.push_back(typed ? vs : classify_sphere(x, y, z, r));
		n_spheres++;
	endtask

	// Drop the sphere valid and wait until every result beat is back.
	task automatic drain_results();
		sphere_valid <= 1'b0;
		while (pending_vs.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == sfc_pkg::REG_BOUND)
			bound_q = data;
		else if (idx == sfc_pkg::REG_ENABLE)
			pretest_on = data[0];
		else
			plane_q[idx] = data;
		@(posedge clk);
	endtask

	// Load a fresh frustum setting; only call with the block drained.
	task automatic program_frustum(frustum_kind_t kind);
		logic [63:0] word;
		int          axis, lo_side, hmax, hsum, rad;
		int          nrm [3];
		n_settings++;
		for (int k = 0; k < 3; k++) begin
			fc[k] = int'($urandom_range(0, 16000)) - 8000;
			fh[k] = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 20))
				: int'($urandom_range(100, 8000));
		end
		for (int i = 0; i < sfc_pkg::PLANE_COUNT; i++) begin
			case (kind)
				FR_BOX: begin
					// near/far on z, left/right on x, bottom/top on y
					axis    = (i < 2) ? 2 : (i < 4) ? 0 : 1;
					lo_side = (i % 2 == 0);
					for (int k = 0; k < 3; k++)
						nrm[k] = int'($urandom_range(0, 2000)) - 1000;
					nrm[axis] = lo_side ? 16384 : -16384;
					word = plane_word(nrm[0], nrm[1], nrm[2],
						lo_side ? fh[axis] - fc[axis] : fh[axis] + fc[axis]);
				end
				FR_WILD:    word = {$urandom, $urandom};
				FR_EXTREME: word = {pick_extreme(), pick_extreme(), pick_extreme(),
					pick_extreme()};
				default:    word = '0;
			endcase
			write_reg(3'(i), word);
		end
		case (kind)
			FR_BOX: begin
				hmax = (fh[0] > fh[1]) ? fh[0] : fh[1];
				hmax = (hmax > fh[2]) ? hmax : fh[2];
				hsum = fh[0] + fh[1] + fh[2];
				rad  = int'($urandom_range(hmax, hsum));
				word = {rad[15:0], 16'(fc[2]), 16'(fc[1]), 16'(fc[0])};
			end
			FR_WILD:    word = {$urandom, $urandom};
			FR_EXTREME: word = {pick_extreme(), pick_extreme(), pick_extreme(),
				pick_extreme()};
			default:    word = '0;
		endcase
		write_reg(sfc_pkg::REG_BOUND, word);
		// random upper bits: only bit 0 counts
		word = {$urandom, $urandom};
		word[0] = (kind == FR_ZERO) ? 1'b0 : 1'($urandom_range(0, 1));
		write_reg(sfc_pkg::REG_ENABLE, word);
	endtask

	// Send one random sphere: mostly close to the frustum, some pure noise.
	task automatic send_random(frustum_kind_t kind);
		logic [15:0] c [3];
		logic [14:0] r;
		int          hmin;
		if ($urandom_range(0, 4) == 0) begin
			for (int k = 0; k < 3; k++)
				c[k] = 16'($urandom);
			r = 15'($urandom);
		end else if (kind == FR_BOX) begin
			hmin = (fh[0] < fh[1]) ? fh[0] : fh[1];
			hmin = (hmin < fh[2]) ? hmin : fh[2];
			for (int k = 0; k < 3; k++)
				c[k] = 16'(fc[k] + int'($urandom_range(0, 3 * fh[k])) - (3 * fh[k]) / 2);
			r = ($urandom_range(0, 9) == 0) ? 15'd0 : 15'($urandom_range(0, hmin / 2 + 1));
		end else begin
			for (int k = 0; k < 3; k++)
				c[k] = 16'(int'($urandom_range(0, 4000)) - 2000);
			r = 15'($urandom_range(0, 3000));
		end
		send_sphere(c[0], c[1], c[2], r);
	endtask

	// Result side: random stall bursts, runs with none, and one long hold-off
	// on request so the chain fills and pushes back on the sphere side.
	initial begin
		result_stall <= 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (long_hold_req) begin
				result_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_req = 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				result_stall <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	// Compare every result beat with the oldest recorded verdict.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			n_results++;
			n_class[view_state]++;
			if (pending_vs.size() == 0) begin
				$error("view_state: no result pending, actual %0d", view_state);
				n_err++;
			end else begin
				vs_want = pending_vs.pop_front();
				if (view_state !== vs_want) begin
					$error("view_state: expected %0d, actual %0d", vs_want, view_state);
					n_err++;
				end
			end
		end
	end

	// Watchdog: end the run when no beat moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (sphere_valid && !sphere_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("watchdog: %0d cycles without a beat, %0d results pending",
				IDLE_LIMIT, pending_vs.size());
			$display("RESULT: ERROR");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		frustum_kind_t phase_kind;
		arst_n       <= 1'b0;
		sphere_valid <= 1'b0;
		center_x     <= '0;
		center_y     <= '0;
		center_z     <= '0;
		radius       <= '0;
		cfg_valid    <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		for (int i = 0; i < sfc_pkg::PLANE_COUNT; i++)
			plane_q[i] = '0;
		bound_q      = '0;
		pretest_on   = 1'b0;
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;

		// After reset every plane is zero: a zero radius is outside, any
		// other radius straddles all six planes.
		dir_rows.push_back(sph(16'h0000, 16'h0000, 16'h0000, 15'h0000, 1,
			sfc_pkg::VIEW_OUTSIDE));
		dir_rows.push_back(sph(16'h0000, 16'h0000, 16'h0000, 15'h0001, 1,
			sfc_pkg::VIEW_PARTIAL));
		dir_rows.push_back(sph(16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h7FFF, 1,
			sfc_pkg::VIEW_PARTIAL));
		dir_rows.push_back(sph(16'h8000, 16'h8000, 16'h8000, 15'h0000, 1,
			sfc_pkg::VIEW_OUTSIDE));
		dir_rows.push_back(sph(16'h8000, 16'h7FFF, 16'hFFFF, 15'h5555, 1,
			sfc_pkg::VIEW_PARTIAL));
		dir_rows.push_back(sph(16'h5555, 16'hAAAA, 16'h0001, 15'h2AAA, 1,
			sfc_pkg::VIEW_PARTIAL));
		// box of +-1000 around the origin, pretest sphere of radius 100
		dir_rows.push_back(cfg(REG_NEAR,   plane_word(0, 0, 16384, 1000)));
		dir_rows.push_back(cfg(REG_FAR,    plane_word(0, 0, -16384, 1000)));
		dir_rows.push_back(cfg(REG_LEFT,   plane_word(16384, 0, 0, 1000)));
		dir_rows.push_back(cfg(REG_RIGHT,  plane_word(-16384, 0, 0, 1000)));
		dir_rows.push_back(cfg(REG_BOTTOM, plane_word(0, 16384, 0, 1000)));
		dir_rows.push_back(cfg(REG_TOP,    plane_word(0, -16384, 0, 1000)));
		dir_rows.push_back(cfg(sfc_pkg::REG_BOUND,  64'h0064_0000_0000_0000));
		dir_rows.push_back(cfg(sfc_pkg::REG_ENABLE, 64'hFFFF_FFFF_FFFF_FFFF));
		// squared distance equal to squared radius sum, then one unit past it
		dir_rows.push_back(sph(16'd60, 16'd80, 16'd0, 15'd0));
		dir_rows.push_back(sph(16'd60, 16'd81, 16'd0, 15'd0));
		dir_rows.push_back(sph(16'd0, 16'd0, 16'd0, 15'h7FFF));
		dir_rows.push_back(cfg(sfc_pkg::REG_ENABLE, 64'hFFFF_FFFF_FFFF_FFFE));
		// walk across the right plane: inside, touching, straddling, behind
		dir_rows.push_back(sph(16'd999, 16'd0, 16'd0, 15'd0));
		dir_rows.push_back(sph(16'd1000, 16'd0, 16'd0, 15'd0));
		dir_rows.push_back(sph(16'd1000, 16'd0, 16'd0, 15'd1));
		dir_rows.push_back(sph(16'd1001, 16'd0, 16'd0, 15'd1));
		dir_rows.push_back(sph(16'd500, -16'sd500, 16'd999, 15'd499));
		// extreme coefficients and an extreme pretest sphere
		dir_rows.push_back(cfg(REG_NEAR,   64'h7FFF_8000_7FFF_8000));
		dir_rows.push_back(cfg(REG_TOP,    64'h8000_7FFF_8000_7FFF));
		dir_rows.push_back(cfg(sfc_pkg::REG_BOUND,  64'hFFFF_8000_7FFF_8000));
		dir_rows.push_back(cfg(sfc_pkg::REG_ENABLE, 64'h0000_0000_0000_0001));
		dir_rows.push_back(sph(16'h8000, 16'h8000, 16'h8000, 15'h7FFF));
		dir_rows.push_back(sph(16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h0000));
		dir_rows.push_back(sph(16'h8000, 16'h7FFF, 16'h8000, 15'h7FFF));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: drain before every register write
		foreach (dir_rows[k]) begin
			if (dir_rows[k].kind == ROW_CFG) begin
				drain_results();
				write_reg(dir_rows[k].idx, dir_rows[k].data);
			end else begin
				send_sphere(dir_rows[k].x, dir_rows[k].y, dir_rows[k].z, dir_rows[k].r,
					dir_rows[k].typed, dir_rows[k].vs);
			end
		end

		// random phases, one frustum setting each; the last runs flat out
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				2:       phase_kind = FR_WILD;
				4:       phase_kind = FR_EXTREME;
				6:       phase_kind = FR_ZERO;
				default: phase_kind = FR_BOX;
			endcase
			drain_results();
			program_frustum(phase_kind);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 7) begin
					src_idle_on  = 1'b0;
					sink_idle_on = 1'b0;
				end else if (n % 40 == 0) begin
					src_idle_on  = ($urandom_range(0, 3) != 0);
					sink_idle_on = ($urandom_range(0, 3) != 0);
				end
				// hold results off for a long stretch while spheres keep coming
				if (ph == 3 && n == 60)
					long_hold_req = 1'b1;
				// pause the sphere side until every result is back
				if (ph == 1 && n == 120)
					drain_results();
				send_random(phase_kind);
			end
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d spheres over %0d frustum settings, %0d results checked",
			n_spheres, n_settings + 1, n_results);
		$display("verdicts seen: %0d outside, %0d partial, %0d inside, %0d mismatches",
			n_class[0], n_class[1], n_class[2], n_err);
		if (n_err == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
